// ===== sv/mhh_pkg.sv =====
package mhh_pkg;

    localparam int WordLen    = 6;
    localparam int CodeBits   = 2 * WordLen;
    localparam int Bins       = 1 << CodeBits;
    localparam int CountWidth = 32;
    localparam int RunWidth   = $clog2(WordLen + 1);

    localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_NEW  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    typedef struct packed {
        logic [1:0]          func;
        logic [7:0]          base_char;
        logic                coding_flag;
        logic [CodeBits-1:0] bin_index;
    } t_in_item;

    typedef struct packed {
        logic                  counted;
        logic [CodeBits-1:0]   hexamer_code;
        logic [CountWidth-1:0] bin_count;
        logic [CountWidth-1:0] total_count;
    } t_out_item;

    typedef struct packed {
        logic                counted;
        logic                is_read;
        logic [CodeBits-1:0] addr;
        logic [CodeBits-1:0] code;
    } t_bin_req;

    // {valid, 2-bit base}
    function automatic logic [2:0] base_decode(input logic [7:0] ch);
        logic [2:0] res;
        case (ch)
            8'h41, 8'h61: res = 3'b100;
            8'h43, 8'h63: res = 3'b101;
            8'h47, 8'h67: res = 3'b110;
            8'h54, 8'h74: res = 3'b111;
            default:      res = 3'b000;
        endcase
        return res;
    endfunction

    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
        return (v == CountMax) ? v : v + 1'b1;
    endfunction

endpackage

// ===== sv/mhh_window.sv =====
module mhh_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  mhh_pkg::t_in_item i_item,
    output mhh_pkg::t_bin_req o_req
);

    logic [mhh_pkg::CodeBits-1:0] r_window, n_window;
    logic [mhh_pkg::RunWidth-1:0] r_run, n_run;
    logic [2:0]                   dec;
    logic                         counted;

    always_comb begin
        n_window = r_window;
        n_run    = r_run;
        counted  = 1'b0;
        dec      = mhh_pkg::base_decode(i_item.base_char);
        case (i_item.func)
            mhh_pkg::FUNC_PUSH: begin
                if (!dec[2]) begin
                    n_run = '0;
                end else begin
                    n_window = {r_window[mhh_pkg::CodeBits-3:0], dec[1:0]};
                    if (i_item.coding_flag) begin
                        n_run = '0;
                    end else begin
                        if (r_run < mhh_pkg::RunWidth'(mhh_pkg::WordLen)) begin
                            n_run = r_run + 1'b1;
                        end
                        counted = (n_run == mhh_pkg::RunWidth'(mhh_pkg::WordLen));
                    end
                end
            end
            mhh_pkg::FUNC_NEW: begin
                n_window = '0;
                n_run    = '0;
            end
            default: begin
            end
        endcase
        o_req.counted = counted;
        o_req.is_read = (i_item.func == mhh_pkg::FUNC_READ);
        o_req.addr    = (i_item.func == mhh_pkg::FUNC_READ) ? i_item.bin_index : n_window;
        o_req.code    = n_window;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_run    <= '0;
        end else if (i_take) begin
            r_window <= n_window;
            r_run    <= n_run;
        end
    end

endmodule

// ===== sv/mhh_bin_ram.sv =====
module mhh_bin_ram (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [mhh_pkg::CodeBits-1:0]   i_rd_addr,
    output logic [mhh_pkg::CountWidth-1:0] o_rd_data,
    input  logic                           i_wr_en,
    input  logic [mhh_pkg::CodeBits-1:0]   i_wr_addr,
    input  logic [mhh_pkg::CountWidth-1:0] i_wr_data
);

    logic [mhh_pkg::CountWidth-1:0] r_mem [mhh_pkg::Bins];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== sv/mhh_count.sv =====
module mhh_count (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  mhh_pkg::t_bin_req              i_req,
    input  logic [mhh_pkg::CountWidth-1:0] i_rd_data,
    input  logic                           i_out_stall,
    output logic                           o_in_stall,
    output logic                           o_wr_en,
    output logic [mhh_pkg::CodeBits-1:0]   o_wr_addr,
    output logic [mhh_pkg::CountWidth-1:0] o_wr_data,
    output logic                           o_out_valid,
    output mhh_pkg::t_out_item             o_out_item
);

    logic                           r_s1_vld;
    mhh_pkg::t_bin_req              r_s1;
    logic                           r_fwd_vld;
    logic [mhh_pkg::CodeBits-1:0]   r_fwd_addr;
    logic [mhh_pkg::CountWidth-1:0] r_fwd_data;
    logic [mhh_pkg::CountWidth-1:0] r_total;
    logic                           r_out_vld;
    mhh_pkg::t_out_item             r_out;
    logic                           r_clr_busy;
    logic [mhh_pkg::CodeBits-1:0]   r_clr_addr;

    logic                           s1_adv;
    logic [mhh_pkg::CountWidth-1:0] bin_cur;
    logic [mhh_pkg::CountWidth-1:0] bin_inc;
    logic [mhh_pkg::CountWidth-1:0] tot_inc;

    // bypass the write that lands on the same edge as this item's read
    assign bin_cur = (r_fwd_vld && (r_fwd_addr == r_s1.addr)) ? r_fwd_data : i_rd_data;
    assign bin_inc = mhh_pkg::sat_inc(bin_cur);
    assign tot_inc = mhh_pkg::sat_inc(r_total);
    assign s1_adv  = r_s1_vld && (!r_out_vld || !i_out_stall);

    assign o_in_stall  = r_clr_busy || (r_s1_vld && !s1_adv);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_comb begin
        if (r_clr_busy) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_clr_addr;
            o_wr_data = '0;
        end else begin
            o_wr_en   = s1_adv && r_s1.counted;
            o_wr_addr = r_s1.addr;
            o_wr_data = bin_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_total    <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == mhh_pkg::CodeBits'(mhh_pkg::Bins - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_take) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (o_wr_en) begin
                r_fwd_vld <= 1'b1;
            end
            if (s1_adv && r_s1.counted) begin
                r_total <= tot_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1 <= i_req;
        end
        if (o_wr_en) begin
            r_fwd_addr <= o_wr_addr;
            r_fwd_data <= o_wr_data;
        end
        if (s1_adv) begin
            r_out.counted      <= r_s1.counted;
            r_out.hexamer_code <= r_s1.code;
            r_out.bin_count    <= r_s1.is_read ? bin_cur : '0;
            r_out.total_count  <= r_s1.counted ? tot_inc : r_total;
        end
    end

endmodule

// ===== sv/masked_hexamer_histogram.sv =====
// channel   direction  handshake                payload
// in        input      i_in_valid / o_in_stall  i_in_item  (mhh_pkg::t_in_item)
// out       output     o_out_valid / i_out_stall o_out_item (mhh_pkg::t_out_item)
//
// One transfer per cycle in each direction while neither side stalls; the bin
// RAM read-modify-write is two stages with a one-entry write bypass, and a
// result passes through the counting stage and then the output register.
// After reset the bin RAM is swept to zero, one entry per cycle: input is
// stalled until all 4096 entries are cleared.
// An output stall holds the output register, then the counting stage, then input.
module masked_hexamer_histogram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mhh_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mhh_pkg::t_out_item o_out_item
);

    logic                           take;
    mhh_pkg::t_bin_req              req;
    logic [mhh_pkg::CountWidth-1:0] rd_data;
    logic                           wr_en;
    logic [mhh_pkg::CodeBits-1:0]   wr_addr;
    logic [mhh_pkg::CountWidth-1:0] wr_data;

    assign take = i_in_valid && !o_in_stall;

    mhh_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_item),
        .o_req   (req)
    );

    mhh_bin_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (take),
        .i_rd_addr (req.addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    mhh_count u_count (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_req       (req),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sv/mhh_checker.sv =====
module mhh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mhh_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mhh_pkg::t_out_item o_out_item
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input transfer changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output transfer changed");

    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during RAM clear");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.counted |-> o_out_item.total_count != '0)
        else $error("counted word with zero total");

    a_count_no_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.counted |-> o_out_item.bin_count == '0)
        else $error("bin count reported on push");

endmodule

bind masked_hexamer_histogram mhh_checker u_mhh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
